FILE: src/lprt_pkg.sv
// lprt_pkg: shared constants, status and command codes, controller/datapath structs
// for the learned power-to-resistance table; no dependencies
`timescale 1ns / 1ps
package lprt_pkg;

  localparam int TABLE_SLOTS    = 32;
  localparam int BUFFER_SAMPLES = 4;
  localparam int TBL_IW         = $clog2(TABLE_SLOTS);
  localparam int FILL_W         = 3;
  localparam int COUNT_CAP      = 10;
  localparam int CAD_WINDOW     = 20;
  localparam int MIN_WATTS      = 10;
  localparam logic signed [15:0] ERR_RES = -16'sd99;

  // shared divider widths
  localparam int DIV_NW = 34;
  localparam int DIV_DW = 17;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // result status codes
  localparam logic [2:0] RS_IGNORED   = 3'd0;
  localparam logic [2:0] RS_BUFFERED  = 3'd1;
  localparam logic [2:0] RS_RESTARTED = 3'd2;
  localparam logic [2:0] RS_COMMITTED = 3'd3;
  localparam logic [2:0] RS_REJECTED  = 3'd4;
  localparam logic [2:0] RS_LOOKUP_OK = 3'd5;
  localparam logic [2:0] RS_LOOKUP_ER = 3'd6;

  // datapath operations
  localparam logic [4:0] OP_NONE       = 5'd0;
  localparam logic [4:0] OP_LOAD       = 5'd1;
  localparam logic [4:0] OP_ADJ_GO     = 5'd2;
  localparam logic [4:0] OP_ADJ_END    = 5'd3;
  localparam logic [4:0] OP_BUF_FIRST  = 5'd4;
  localparam logic [4:0] OP_BUF_ACC    = 5'd5;
  localparam logic [4:0] OP_IDX_GO     = 5'd6;
  localparam logic [4:0] OP_LKI_GO     = 5'd7;
  localparam logic [4:0] OP_IDX_END    = 5'd8;
  localparam logic [4:0] OP_DEC        = 5'd9;
  localparam logic [4:0] OP_INC        = 5'd10;
  localparam logic [4:0] OP_JR_INIT    = 5'd11;
  localparam logic [4:0] OP_MARK       = 5'd12;
  localparam logic [4:0] OP_SLOT_NEW   = 5'd13;
  localparam logic [4:0] OP_BW_GO      = 5'd14;
  localparam logic [4:0] OP_BW_END     = 5'd15;
  localparam logic [4:0] OP_BR_GO      = 5'd16;
  localparam logic [4:0] OP_SLOT_BLEND = 5'd17;
  localparam logic [4:0] OP_FIND_INIT  = 5'd18;
  localparam logic [4:0] OP_FIND_STEP  = 5'd19;
  localparam logic [4:0] OP_FIND_TAKE  = 5'd20;
  localparam logic [4:0] OP_PAIR       = 5'd21;
  localparam logic [4:0] OP_INT_A      = 5'd22;
  localparam logic [4:0] OP_INT_B      = 5'd23;
  localparam logic [4:0] OP_INT_C      = 5'd24;
  localparam logic [4:0] OP_Q_GO       = 5'd25;
  localparam logic [4:0] OP_Q_END      = 5'd26;

  typedef struct packed {
    logic [4:0] op;
    logic       clr_buf;
    logic       load_out;
    logic [2:0] status;
  } lprt_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic gate_ok;
    logic div_done;
    logic a_zero;
    logic s_zero;
    logic fill_zero;
    logic too_far;
    logic fill_last;
    logic q_oor;
    logic left_done;
    logic hit_l;
    logic idx_last;
    logic j_last;
    logic hit_r;
    logic n_zero;
    logic find_hit;
    logic find_end;
    logic lk_bad;
  } lprt_sts_t;

endpackage

FILE: src/lprt_div.sv
// lprt_div: restoring unsigned divider, one quotient bit per cycle
// depends on lprt_pkg
`timescale 1ns / 1ps
module lprt_div import lprt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quot
);

  logic              busy_r, done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_DW:0]   trial;
  logic              fits;

  assign trial = {rem_r, q_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DIV_DW'(trial - {1'b0, den_r});
        q_r   <= {q_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_DW-1:0];
        q_r   <= {q_r[DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: src/lprt_dp.sv
// lprt_dp: datapath with slot table, sample buffer, lookup registers and result register
// depends on lprt_pkg and lprt_div
`timescale 1ns / 1ps
module lprt_dp import lprt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lprt_cmd_t          cmd,
  input  logic               in_action,
  input  logic [11:0]        in_power_watts,
  input  logic [7:0]         in_cadence_rpm,
  input  logic signed [15:0] in_resistance_now,
  input  logic [7:0]         cfg_n,
  input  logic [7:0]         cfg_s,
  output lprt_sts_t          sts,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_resistance_out
);

  // slot table
  logic [15:0]        slot_w_r [TABLE_SLOTS];
  logic signed [15:0] slot_r_r [TABLE_SLOTS];
  logic [3:0]         slot_n_r [TABLE_SLOTS];

  // item and buffer
  logic               act_r;
  logic [11:0]        w_r;
  logic [7:0]         c_r;
  logic signed [15:0] r_r;
  logic [15:0]        a_r;
  logic [FILL_W-1:0]  fill_r;
  logic [11:0]        first_r;
  logic [15:0]        avgw_r;
  logic signed [15:0] avgr_r;

  // scan and lookup
  logic [TBL_IW-1:0]  idx_r, j_r, x_r, cen_r, p_r;
  logic [15:0]        tmpw_r;
  logic signed [16:0] den_r, dw_r, dr_r;
  logic signed [15:0] rb_r, q_r;
  logic signed [32:0] p1_r;
  logic signed [33:0] p2_r;
  logic [DIV_NW-1:0]  nmag_r;
  logic [DIV_DW-1:0]  dmag_r;
  logic               neg_r;
  logic [2:0]         out_status_r;
  logic signed [15:0] out_res_r;

  // divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;

  lprt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // combinational helpers
  logic [20:0]        adj_prod;
  logic [15:0]        lim;
  logic [11:0]        diff;
  logic [3:0]         n_sel;
  logic [20:0]        bw_sum;
  logic signed [20:0] br_prod, br_sum;
  logic [20:0]        br_mag;
  logic [TBL_IW:0]    up;
  logic               up_hit, down_hit;
  logic [TBL_IW-1:0]  down, find_idx, lo, hi;
  logic [15:0]        pb, pa;
  logic signed [15:0] rb, ra;
  logic signed [34:0] nsum, nfix;
  logic signed [16:0] br_new;
  logic signed [16:0] acc_sum;

  assign adj_prod = 21'(w_r) * 21'({1'b0, cfg_n} + {1'b0, c_r});
  assign lim      = 16'(TABLE_SLOTS) * 16'(cfg_s);
  assign diff     = (first_r > w_r) ? first_r - w_r : w_r - first_r;
  assign n_sel    = slot_n_r[idx_r];
  assign bw_sum   = 21'(avgw_r) + 21'(slot_w_r[idx_r]) * 21'(n_sel);
  assign br_prod  = slot_r_r[idx_r] * $signed({1'b0, n_sel});
  assign br_sum   = br_prod + {{5{avgr_r[15]}}, avgr_r};
  assign br_mag   = br_sum[20] ? 21'(-br_sum) : 21'(br_sum);
  assign acc_sum  = {avgr_r[15], avgr_r} + {r_r[15], r_r};

  assign up       = {1'b0, cen_r} + {1'b0, x_r};
  assign down     = cen_r - x_r;
  assign up_hit   = (up < (TBL_IW+1)'(TABLE_SLOTS)) && (slot_n_r[up[TBL_IW-1:0]] != 4'd0);
  assign down_hit = (x_r <= cen_r) && (slot_n_r[down] != 4'd0);
  assign find_idx = up_hit ? up[TBL_IW-1:0] : down;

  assign lo = (idx_r < p_r) ? idx_r : p_r;
  assign hi = (idx_r < p_r) ? p_r : idx_r;
  assign pb = slot_w_r[lo];
  assign pa = slot_w_r[hi];
  assign rb = slot_r_r[lo];
  assign ra = slot_r_r[hi];

  assign nsum   = {{2{p1_r[32]}}, p1_r} + {p2_r[33], p2_r};
  assign nfix   = den_r[16] ? -nsum : nsum;
  assign br_new = neg_r ? -$signed({1'b0, div_quot[15:0]}) : $signed({1'b0, div_quot[15:0]});

  // divider operand select
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_ADJ_GO: begin
        div_num = DIV_NW'(adj_prod);
        div_den = DIV_DW'({c_r, 1'b0});
      end
      OP_IDX_GO: begin
        div_num = DIV_NW'({1'b0, avgw_r} + 17'(cfg_s[7:1]));
        div_den = DIV_DW'(cfg_s);
      end
      OP_LKI_GO: begin
        div_num = DIV_NW'(a_r);
        div_den = DIV_DW'(cfg_s);
      end
      OP_BW_GO: begin
        div_num = DIV_NW'(bw_sum);
        div_den = DIV_DW'({1'b0, n_sel} + 5'd1);
      end
      OP_BR_GO: begin
        div_num = DIV_NW'(br_mag);
        div_den = DIV_DW'({1'b0, n_sel} + 5'd1);
      end
      OP_Q_GO: begin
        div_num = nmag_r;
        div_den = dmag_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  // table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_SLOTS; k++) begin
        slot_w_r[k] <= '0;
        slot_r_r[k] <= '0;
        slot_n_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_MARK: slot_n_r[j_r] <= 4'd1;
        OP_SLOT_NEW: begin
          slot_w_r[idx_r] <= avgw_r;
          slot_r_r[idx_r] <= avgr_r;
          slot_n_r[idx_r] <= 4'd1;
        end
        OP_SLOT_BLEND: begin
          slot_w_r[idx_r] <= tmpw_r;
          slot_r_r[idx_r] <= br_new[15:0];
          slot_n_r[idx_r] <= (n_sel >= 4'(COUNT_CAP)) ? 4'(COUNT_CAP) : n_sel + 4'd1;
        end
        default: ;
      endcase
    end
  end

  // sample buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      first_r <= '0;
      avgw_r  <= '0;
      avgr_r  <= '0;
    end else if (cmd.clr_buf) begin
      fill_r  <= '0;
      first_r <= '0;
      avgw_r  <= '0;
      avgr_r  <= '0;
    end else if (cmd.op == OP_BUF_FIRST) begin
      fill_r  <= FILL_W'(1);
      first_r <= w_r;
      avgw_r  <= a_r;
      avgr_r  <= r_r;
    end else if (cmd.op == OP_BUF_ACC) begin
      fill_r  <= fill_r + 1'b1;
      avgw_r  <= 16'(({1'b0, avgw_r} + {1'b0, a_r}) >> 1);
      // halve the 17-bit sum, truncating toward zero
      avgr_r  <= 16'((acc_sum + $signed({16'd0, acc_sum[16]})) >>> 1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_status_r <= RS_IGNORED;
    end else if (cmd.load_out) begin
      out_status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r <= in_action;
        w_r   <= in_power_watts;
        c_r   <= in_cadence_rpm;
        r_r   <= in_resistance_now;
      end
      OP_ADJ_END: begin
        if (c_r == 8'd0)                   a_r <= '0;
        else if (div_quot > DIV_NW'(65535)) a_r <= 16'hFFFF;
        else                               a_r <= div_quot[15:0];
      end
      OP_IDX_END: begin
        idx_r <= div_quot[TBL_IW-1:0];
        j_r   <= div_quot[TBL_IW-1:0] - 1'b1;
      end
      OP_DEC:       j_r <= j_r - 1'b1;
      OP_INC:       j_r <= j_r + 1'b1;
      OP_JR_INIT:   j_r <= idx_r + 1'b1;
      OP_BW_END:    tmpw_r <= div_quot[15:0];
      OP_BR_GO:     neg_r <= br_sum[20];
      OP_FIND_INIT: begin
        cen_r <= idx_r;
        x_r   <= TBL_IW'(1);
      end
      OP_FIND_STEP: x_r <= x_r + 1'b1;
      OP_FIND_TAKE: idx_r <= find_idx;
      OP_PAIR:      p_r <= find_idx;
      OP_INT_A: begin
        den_r <= $signed({1'b0, pa}) - $signed({1'b0, pb});
        dw_r  <= $signed({1'b0, a_r}) - $signed({1'b0, pb});
        dr_r  <= $signed({ra[15], ra}) - $signed({rb[15], rb});
        rb_r  <= rb;
      end
      OP_INT_B: begin
        p1_r <= rb_r * den_r;
        p2_r <= dw_r * dr_r;
      end
      OP_INT_C: begin
        neg_r  <= nfix[34];
        nmag_r <= nfix[34] ? DIV_NW'(-nfix) : DIV_NW'(nfix);
        dmag_r <= den_r[16] ? DIV_DW'(-den_r) : DIV_DW'(den_r);
      end
      OP_Q_END: begin
        if (neg_r)
          q_r <= (div_quot > DIV_NW'(32768)) ? -16'sd32768 : -$signed(div_quot[15:0]);
        else
          q_r <= (div_quot > DIV_NW'(32767)) ? 16'sd32767 : $signed(div_quot[15:0]);
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      if (cmd.status == RS_LOOKUP_OK)      out_res_r <= q_r;
      else if (cmd.status == RS_LOOKUP_ER) out_res_r <= ERR_RES;
      else                                 out_res_r <= '0;
    end
  end

  // status to the controller
  always_comb begin
    sts.is_lookup = act_r;
    sts.gate_ok   = ({2'b0, c_r} + 10'(CAD_WINDOW) >= {2'b0, cfg_n})
                 && ({2'b0, c_r} <= {2'b0, cfg_n} + 10'(CAD_WINDOW))
                 && (w_r > 12'(MIN_WATTS))
                 && ({4'b0, w_r} < lim);
    sts.div_done  = div_done;
    sts.a_zero    = (a_r == 16'd0);
    sts.s_zero    = (cfg_s == 8'd0);
    sts.fill_zero = (fill_r == '0);
    sts.too_far   = (diff >= {5'd0, cfg_s[7:1]});
    sts.fill_last = (fill_r == FILL_W'(BUFFER_SAMPLES - 1));
    sts.q_oor     = (div_quot >= DIV_NW'(TABLE_SLOTS));
    sts.left_done = (idx_r == '0) || (j_r == '0);
    sts.hit_l     = (slot_r_r[j_r] != 16'sd0) && (slot_r_r[j_r] >= avgr_r);
    sts.idx_last  = (idx_r == TBL_IW'(TABLE_SLOTS - 1));
    sts.j_last    = (j_r == TBL_IW'(TABLE_SLOTS - 1));
    sts.hit_r     = (slot_r_r[j_r] != 16'sd0) && (avgr_r >= slot_r_r[j_r]);
    sts.n_zero    = (n_sel == 4'd0);
    sts.find_hit  = up_hit || down_hit;
    sts.find_end  = (x_r == TBL_IW'(TABLE_SLOTS - 1));
    sts.lk_bad    = (rb >= ra) || (pb == 16'd0) || (pa == 16'd0) || (pa == pb);
  end

  assign out_status         = out_status_r;
  assign out_resistance_out = out_res_r;

endmodule

FILE: src/lprt_ctrl.sv
// lprt_ctrl: sequencing state machine, issues at most one datapath command per cycle
// depends on lprt_pkg
`timescale 1ns / 1ps
module lprt_ctrl import lprt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  input  lprt_sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output lprt_cmd_t cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_ADJ    = 5'd2;
  localparam logic [4:0] S_BRANCH = 5'd3;
  localparam logic [4:0] S_CIDX0  = 5'd4;
  localparam logic [4:0] S_CIDX   = 5'd5;
  localparam logic [4:0] S_SCANL  = 5'd6;
  localparam logic [4:0] S_SCANR  = 5'd7;
  localparam logic [4:0] S_BLEND  = 5'd8;
  localparam logic [4:0] S_BW     = 5'd9;
  localparam logic [4:0] S_BR0    = 5'd10;
  localparam logic [4:0] S_BR     = 5'd11;
  localparam logic [4:0] S_LKI    = 5'd12;
  localparam logic [4:0] S_LK1    = 5'd13;
  localparam logic [4:0] S_FIND1  = 5'd14;
  localparam logic [4:0] S_LK2    = 5'd15;
  localparam logic [4:0] S_FIND2  = 5'd16;
  localparam logic [4:0] S_INT0   = 5'd17;
  localparam logic [4:0] S_INT1   = 5'd18;
  localparam logic [4:0] S_INT2   = 5'd19;
  localparam logic [4:0] S_INT3   = 5'd20;
  localparam logic [4:0] S_Q      = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  logic [4:0] state_r, state_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    stat_nxt     = stat_r;
    cmd.op       = OP_NONE;
    cmd.clr_buf  = 1'b0;
    cmd.load_out = 1'b0;
    cmd.status   = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.is_lookup && !sts.gate_ok) begin
          stat_nxt  = RS_IGNORED;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_ADJ_GO;
          state_nxt = S_ADJ;
        end
      end
      S_ADJ: begin
        if (sts.div_done) begin
          cmd.op    = OP_ADJ_END;
          state_nxt = S_BRANCH;
        end
      end
      S_BRANCH: begin
        if (sts.is_lookup) begin
          if (sts.a_zero || sts.s_zero) begin
            stat_nxt  = RS_LOOKUP_ER;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_LKI_GO;
            state_nxt = S_LKI;
          end
        end else if (sts.fill_zero) begin
          cmd.op    = OP_BUF_FIRST;
          stat_nxt  = RS_BUFFERED;
          state_nxt = S_DONE;
        end else if (sts.too_far) begin
          cmd.clr_buf = 1'b1;
          stat_nxt    = RS_RESTARTED;
          state_nxt   = S_DONE;
        end else begin
          cmd.op = OP_BUF_ACC;
          if (sts.fill_last) begin
            state_nxt = S_CIDX0;
          end else begin
            stat_nxt  = RS_BUFFERED;
            state_nxt = S_DONE;
          end
        end
      end
      S_CIDX0: begin
        cmd.op    = OP_IDX_GO;
        state_nxt = S_CIDX;
      end
      S_CIDX: begin
        if (sts.div_done) begin
          if (sts.q_oor) begin
            cmd.clr_buf = 1'b1;
            stat_nxt    = RS_REJECTED;
            state_nxt   = S_DONE;
          end else begin
            cmd.op    = OP_IDX_END;
            state_nxt = S_SCANL;
          end
        end
      end
      S_SCANL: begin
        if (sts.left_done) begin
          cmd.op    = OP_JR_INIT;
          state_nxt = S_SCANR;
        end else if (sts.hit_l) begin
          cmd.op      = OP_MARK;
          cmd.clr_buf = 1'b1;
          stat_nxt    = RS_REJECTED;
          state_nxt   = S_DONE;
        end else begin
          cmd.op = OP_DEC;
        end
      end
      S_SCANR: begin
        if (sts.idx_last) begin
          state_nxt = S_BLEND;
        end else if (sts.hit_r) begin
          cmd.op      = OP_MARK;
          cmd.clr_buf = 1'b1;
          stat_nxt    = RS_REJECTED;
          state_nxt   = S_DONE;
        end else if (sts.j_last) begin
          state_nxt = S_BLEND;
        end else begin
          cmd.op = OP_INC;
        end
      end
      S_BLEND: begin
        if (sts.n_zero) begin
          cmd.op      = OP_SLOT_NEW;
          cmd.clr_buf = 1'b1;
          stat_nxt    = RS_COMMITTED;
          state_nxt   = S_DONE;
        end else begin
          cmd.op    = OP_BW_GO;
          state_nxt = S_BW;
        end
      end
      S_BW: begin
        if (sts.div_done) begin
          cmd.op    = OP_BW_END;
          state_nxt = S_BR0;
        end
      end
      S_BR0: begin
        cmd.op    = OP_BR_GO;
        state_nxt = S_BR;
      end
      S_BR: begin
        if (sts.div_done) begin
          cmd.op      = OP_SLOT_BLEND;
          cmd.clr_buf = 1'b1;
          stat_nxt    = RS_COMMITTED;
          state_nxt   = S_DONE;
        end
      end
      S_LKI: begin
        if (sts.div_done) begin
          if (sts.q_oor) begin
            stat_nxt  = RS_LOOKUP_ER;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_IDX_END;
            state_nxt = S_LK1;
          end
        end
      end
      S_LK1: begin
        cmd.op    = OP_FIND_INIT;
        state_nxt = sts.n_zero ? S_FIND1 : S_FIND2;
      end
      S_FIND1: begin
        if (sts.find_hit) begin
          cmd.op    = OP_FIND_TAKE;
          state_nxt = S_LK2;
        end else if (sts.find_end) begin
          stat_nxt  = RS_LOOKUP_ER;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_FIND_STEP;
        end
      end
      S_LK2: begin
        cmd.op    = OP_FIND_INIT;
        state_nxt = S_FIND2;
      end
      S_FIND2: begin
        if (sts.find_hit) begin
          cmd.op    = OP_PAIR;
          state_nxt = S_INT0;
        end else if (sts.find_end) begin
          stat_nxt  = RS_LOOKUP_ER;
          state_nxt = S_DONE;
        end else begin
          cmd.op = OP_FIND_STEP;
        end
      end
      S_INT0: begin
        if (sts.lk_bad) begin
          stat_nxt  = RS_LOOKUP_ER;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_INT_A;
          state_nxt = S_INT1;
        end
      end
      S_INT1: begin
        cmd.op    = OP_INT_B;
        state_nxt = S_INT2;
      end
      S_INT2: begin
        cmd.op    = OP_INT_C;
        state_nxt = S_INT3;
      end
      S_INT3: begin
        cmd.op    = OP_Q_GO;
        state_nxt = S_Q;
      end
      S_Q: begin
        if (sts.div_done) begin
          cmd.op    = OP_Q_END;
          stat_nxt  = RS_LOOKUP_OK;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stat_r      <= RS_IGNORED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: src/learned_power_resistance_table.sv
// learned_power_resistance_table: top level with config registers, controller and datapath
// depends on lprt_pkg, lprt_ctrl, lprt_dp (and lprt_div below it)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | input     | in_valid / in_ready     | action, power_watts, cadence, resistance
//  out     | output    | out_valid / out_ready   | status, resistance_out
//  cfg     | input     | psel/penable/pwrite     | normal_cadence @0x0, power_step @0x4
//
//  one item at a time: in_ready is high only while the controller is idle
//  the shared divider resolves one quotient bit per cycle, and the neighbor scans
//  and nearest-slot searches walk one slot per cycle
//  synchronous active-low reset clears the whole slot table, the buffer and the
//  config registers to 90 rpm and 50 W
//  the result register lets the next transfer in while a result waits on out_ready
`timescale 1ns / 1ps
module learned_power_resistance_table import lprt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [11:0]        in_power_watts,
  input  logic [7:0]         in_cadence_rpm,
  input  logic signed [15:0] in_resistance_now,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_resistance_out,
  // config port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [7:0] cfg_n_r, cfg_s_r;
  logic       cfg_wr;
  lprt_cmd_t  cmd;
  lprt_sts_t  sts;

  // config write on the access phase; pready is tied high
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_n_r <= 8'd90;
      cfg_s_r <= 8'd50;
    end else if (cfg_wr) begin
      // word select only; byte offsets inside a word are ignored
      if (cfg_paddr[2]) cfg_s_r <= cfg_pwdata[7:0];
      else              cfg_n_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {24'd0, cfg_s_r} : {24'd0, cfg_n_r};

  // sequencing
  lprt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // table, buffer, arithmetic and result register
  lprt_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_action          (in_action),
    .in_power_watts     (in_power_watts),
    .in_cadence_rpm     (in_cadence_rpm),
    .in_resistance_now  (in_resistance_now),
    .cfg_n              (cfg_n_r),
    .cfg_s              (cfg_s_r),
    .sts                (sts),
    .out_status         (out_status),
    .out_resistance_out (out_resistance_out)
  );

endmodule

FILE: src/lprt_chk.sv
// lprt_chk: port-level checker bound to the top level
// depends on lprt_pkg and learned_power_resistance_table
`timescale 1ns / 1ps
module lprt_chk import lprt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic signed [15:0] out_resistance_out
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_resistance_out))
    else $error("result changed while stalled");

  // one item in flight: busy right after a transfer in
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_sample_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == RS_IGNORED || out_status == RS_BUFFERED
      || out_status == RS_RESTARTED || out_status == RS_COMMITTED
      || out_status == RS_REJECTED) |-> out_resistance_out == 16'sd0)
    else $error("sample result with nonzero resistance");

  a_err_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == RS_LOOKUP_ER |-> out_resistance_out == ERR_RES)
    else $error("lookup error without error resistance");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 3'd7)
    else $error("undefined status code");

endmodule

bind learned_power_resistance_table lprt_chk u_lprt_chk (.*);

FILE: test/tb_learned_power_resistance_table.sv
// tb_learned_power_resistance_table: self-checking testbench for the learned power table
// depends on lprt_pkg and learned_power_resistance_table
`timescale 1ns / 1ps
module tb_learned_power_resistance_table;
  import lprt_pkg::*;

  // item kinds and register addresses
  localparam logic       ACT_SAMPLE  = 1'b0;
  localparam logic       ACT_LOOKUP  = 1'b1;
  localparam logic [2:0] ADDR_CADENCE = 3'd0;
  localparam logic [2:0] ADDR_STEP    = 3'd4;
  localparam int         CYCLE_LIMIT = 3000000;
  localparam int         SETTLE_CYCLES = 300;

  typedef struct {
    logic [2:0]         status;
    logic signed [15:0] res;
  } table_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_action;
  logic [11:0]        in_power_watts;
  logic [7:0]         in_cadence_rpm;
  logic signed [15:0] in_resistance_now;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic signed [15:0] out_resistance_out;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [2:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  learned_power_resistance_table u_dut (.*);

  // predicted state of the table
  int unsigned cad_norm;
  int unsigned step_w;
  int unsigned slot_pw [TABLE_SLOTS];
  int          slot_rs [TABLE_SLOTS];
  int unsigned slot_n  [TABLE_SLOTS];
  int unsigned buf_fill;
  int unsigned buf_first;
  int unsigned buf_avg_w;
  int          buf_avg_r;

  table_result_t pending_results[$];
  int            error_count;
  int            cycle_count;
  bit            idle_on;
  int            hold_left;
  int            long_hold_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned adjusted_watts(int unsigned w, int unsigned c);
    int unsigned v;
    if (c == 0) return 0;
    v = (w * (cad_norm + c)) / (2 * c);
    return (v > 65535) ? 65535 : v;
  endfunction

  // nearest filled slot, checking above before below at each distance
  function automatic int nearest_filled(int centre);
    for (int x = 1; x < TABLE_SLOTS; x++) begin
      if (centre + x < TABLE_SLOTS && slot_n[centre + x] > 0) return centre + x;
      if (centre - x >= 0 && slot_n[centre - x] > 0) return centre - x;
    end
    return -1;
  endfunction

  function automatic void clear_buffer();
    buf_fill  = 0;
    buf_first = 0;
    buf_avg_w = 0;
    buf_avg_r = 0;
  endfunction

  function automatic logic [2:0] commit_buffer();
    int unsigned idx;
    int unsigned n;
    idx = (buf_avg_w + step_w / 2) / step_w;
    if (idx >= TABLE_SLOTS) return RS_REJECTED;
    // left neighbors, slot 0 never checked
    for (int j = int'(idx) - 1; j > 0; j--) begin
      if (slot_rs[j] != 0 && slot_rs[j] >= buf_avg_r) begin
        slot_n[j] = 1;
        return RS_REJECTED;
      end
    end
    for (int j = int'(idx) + 1; j < TABLE_SLOTS; j++) begin
      if (slot_rs[j] != 0 && buf_avg_r >= slot_rs[j]) begin
        slot_n[j] = 1;
        return RS_REJECTED;
      end
    end
    n = slot_n[idx];
    if (n == 0) begin
      slot_pw[idx] = buf_avg_w;
      slot_rs[idx] = buf_avg_r;
      slot_n[idx]  = 1;
    end else begin
      slot_pw[idx] = (buf_avg_w + slot_pw[idx] * n) / (n + 1);
      slot_rs[idx] = (buf_avg_r + slot_rs[idx] * int'(n)) / int'(n + 1);
      slot_n[idx]  = (n + 1 > COUNT_CAP) ? COUNT_CAP : n + 1;
    end
    return RS_COMMITTED;
  endfunction

  function automatic logic [2:0] learn_sample(int unsigned w, int unsigned c, int r);
    int unsigned a;
    int unsigned diff;
    logic [2:0]  st;
    if (int'(c) < int'(cad_norm) - CAD_WINDOW || int'(c) > int'(cad_norm) + CAD_WINDOW)
      return RS_IGNORED;
    if (w <= MIN_WATTS || w >= TABLE_SLOTS * step_w) return RS_IGNORED;
    a = adjusted_watts(w, c);
    if (buf_fill == 0) begin
      buf_fill  = 1;
      buf_first = w;
      buf_avg_w = a;
      buf_avg_r = r;
      return RS_BUFFERED;
    end
    diff = (buf_first > w) ? buf_first - w : w - buf_first;
    if (diff >= step_w / 2) begin
      clear_buffer();
      return RS_RESTARTED;
    end
    buf_fill++;
    buf_avg_w = (buf_avg_w + a) / 2;
    buf_avg_r = (buf_avg_r + r) / 2;
    if (buf_fill < BUFFER_SAMPLES) return RS_BUFFERED;
    st = commit_buffer();
    clear_buffer();
    return st;
  endfunction

  function automatic bit interpolate(int unsigned w, int unsigned c,
                                     output logic signed [15:0] res);
    int unsigned a;
    int          i, p, lo, hi;
    longint      pb, pa, rb, ra, num, den, q;
    res = 0;
    a = adjusted_watts(w, c);
    if (a == 0 || step_w == 0) return 0;
    if (a / step_w >= TABLE_SLOTS) return 0;
    i = int'(a / step_w);
    if (slot_n[i] == 0) begin
      i = nearest_filled(i);
      if (i < 0) return 0;
    end
    p = nearest_filled(i);
    if (p < 0) return 0;
    lo = (i < p) ? i : p;
    hi = (i < p) ? p : i;
    pb = slot_pw[lo];
    pa = slot_pw[hi];
    rb = slot_rs[lo];
    ra = slot_rs[hi];
    if (rb >= ra) return 0;
    if (pb == 0 || pa == 0 || pa == pb) return 0;
    den = pa - pb;
    num = rb * den + (longint'(a) - pb) * (ra - rb);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    q = num / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res = q[15:0];
    return 1;
  endfunction

  function automatic table_result_t predict_item(logic act, int unsigned w,
                                                 int unsigned c, int r);
    table_result_t t;
    logic signed [15:0] v;
    if (act == ACT_SAMPLE) begin
      t.status = learn_sample(w, c, r);
      t.res    = 0;
    end else if (interpolate(w, c, v)) begin
      t.status = RS_LOOKUP_OK;
      t.res    = v;
    end else begin
      t.status = RS_LOOKUP_ER;
      t.res    = ERR_RES;
    end
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, long hold-off and checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (long_hold_left > 0) begin
      long_hold_left--;
      out_ready = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready = 0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold_left = $urandom_range(0, 16);
      out_ready = 0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_resistance_out !== want.res)
          report_mismatch($sformatf("resistance %0d, expected %0d",
                                    out_resistance_out, want.res));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // one input transfer; prediction runs at the accepting edge
  task automatic send_item(logic act, int unsigned w, int unsigned c, int r);
    @(negedge clk);
    in_action         = act;
    in_power_watts    = w[11:0];
    in_cadence_rpm    = c[7:0];
    in_resistance_now = r[15:0];
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_item(act, w[11:0], c[7:0], int'(in_resistance_now)));
    if (idle_on && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int unsigned value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 0;
    cfg_paddr   = addr;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_CADENCE) cad_norm = value & 8'hFF;
    else step_w = value & 8'hFF;
    @(negedge clk);
    cfg_psel    = 0;
    cfg_penable = 0;
  endtask

  task automatic set_config(int unsigned cad, int unsigned step);
    wait_drained();
    write_reg(ADDR_CADENCE, cad);
    write_reg(ADDR_STEP, step);
  endtask

  function automatic int unsigned window_cadence();
    return $urandom_range((cad_norm + 20 > 255) ? 255 : cad_norm + 20, cad_norm - 20);
  endfunction

  // mostly well-formed clusters of samples near one power, plus lookups and noise
  task automatic random_items(int count);
    int          sent;
    int unsigned top, base, w, off;
    int          r;
    sent = 0;
    top  = (TABLE_SLOTS * step_w - 1 > 4095) ? 4095 : TABLE_SLOTS * step_w - 1;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          base = $urandom_range(top, MIN_WATTS + 1);
          for (int k = 0; k < BUFFER_SAMPLES; k++) begin
            off = (k == 0) ? 0 : $urandom_range(0, step_w / 2 - 1);
            w = $urandom_range(0, 1) ? base + off : base - off;
            if (w > top) w = top;
            if (w <= MIN_WATTS) w = MIN_WATTS + 1;
            // resistance rising with power keeps most commits monotonic
            r = (k == 3 && $urandom_range(0, 19) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                     : int'(w) * 4 + int'($urandom_range(0, 40));
            send_item(ACT_SAMPLE, w, window_cadence(), r);
          end
          sent += BUFFER_SAMPLES;
        end
        6, 7: begin
          send_item(ACT_LOOKUP, $urandom_range(top, 1), window_cadence(), $urandom_range(0, 65535));
          sent++;
        end
        default: begin
          send_item(1'($urandom_range(0, 1)), $urandom_range(0, 4095), $urandom_range(0, 255),
                    $urandom_range(0, 65535));
          sent++;
        end
      endcase
    end
  endtask

  task automatic commit_run(int unsigned w, int unsigned c, int r);
    repeat (BUFFER_SAMPLES) send_item(ACT_SAMPLE, w, c, r);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_item(ACT_LOOKUP, 300, 90, 0);          // empty table
    send_item(ACT_SAMPLE, 300, 69, 5);          // cadence just below the window
    send_item(ACT_SAMPLE, 300, 111, 5);         // cadence just above the window
    send_item(ACT_SAMPLE, 10, 90, 5);           // power at the minimum
    send_item(ACT_SAMPLE, 1600, 90, 5);         // power at the top of the table
    send_item(ACT_SAMPLE, 4095, 255, -32768);   // all extremes, ignored
    send_item(ACT_LOOKUP, 300, 0, 32767);       // zero cadence gives zero power
    commit_run(200, 90, 100);                   // commit into slot 4
    send_item(ACT_SAMPLE, 400, 90, 300);
    send_item(ACT_SAMPLE, 500, 90, 300);        // too far from first, restart
    commit_run(400, 90, 300);                   // commit into slot 8
    send_item(ACT_LOOKUP, 300, 90, 0);          // interpolate between the two
    commit_run(600, 90, 50);                    // breaks monotonic order, rejected
    commit_run(1500, 70, 900);                  // slot index beyond the table
    send_item(ACT_LOOKUP, 4095, 90, 0);         // index beyond the table
    wait_drained();
  endtask

  task automatic test_config_sweep();
    set_config(40, 10);
    random_items(280);
    set_config(200, 200);
    random_items(280);
    set_config(90, 50);
    random_items(280);
    set_config(200, 10);
    random_items(300);
    set_config($urandom_range(200, 40), $urandom_range(200, 10));
    random_items(300);
  endtask

  // receiver holds off long enough that the block and its result register fill up
  task automatic test_backpressure();
    @(posedge clk);
    long_hold_left = 600;
    random_items(60);
    wait_drained();
  endtask

  // sender pauses until every result is back, then goes on
  task automatic test_sender_pause();
    random_items(40);
    @(negedge clk);
    in_valid = 0;
    while (pending_results.size() != 0) @(posedge clk);
    random_items(40);
  endtask

  task automatic test_full_rate();
    wait_drained();
    idle_on = 0;
    random_items(150);
  endtask

  initial begin
    rst_n             = 0;
    in_valid          = 0;
    in_action         = 0;
    in_power_watts    = 0;
    in_cadence_rpm    = 0;
    in_resistance_now = 0;
    out_ready         = 0;
    cfg_psel          = 0;
    cfg_penable       = 0;
    cfg_pwrite        = 0;
    cfg_paddr         = 0;
    cfg_pwdata        = 0;
    error_count       = 0;
    cycle_count       = 0;
    idle_on           = 1'b1;
    hold_left         = 0;
    long_hold_left    = 0;
    cad_norm          = 90;
    step_w            = 50;
    foreach (slot_pw[k]) begin
      slot_pw[k] = 0;
      slot_rs[k] = 0;
      slot_n[k]  = 0;
    end
    clear_buffer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_sender_pause();
    test_full_rate();
    wait_drained();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/lprt_pkg.sv
src/lprt_div.sv
src/lprt_dp.sv
src/lprt_ctrl.sv
src/learned_power_resistance_table.sv
src/lprt_chk.sv
test/tb_learned_power_resistance_table.sv
